// ----- sv/mppc_pkg.sv -----
// Package for the motor position PI controller: widths, codes and the
// structs passed between the tracking stage and the PI datapath. No dependencies.
package mppc_pkg;

	localparam int CTRL_PERIOD   = 10;  // ticks between PI updates, 1..16
	localparam int INTEG_W       = 32;  // integral accumulator width, 16..48
	localparam int PHASE_W       = 4;
	localparam int CNT_W         = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 8;
	localparam int PWM_W         = 8;
	localparam int PROD_KP_W     = 2 * CFG_W;
	localparam int PROD_KI_W     = CFG_W + INTEG_W;
	localparam int SUM_W         = PROD_KI_W + 1;

	localparam logic [CFG_W-1:0] TARGET_RST = 16'd29;
	localparam logic [CFG_W-1:0] KP_RST     = 16'd485;
	localparam logic [CFG_W-1:0] KI_RST     = 16'd8;
	localparam logic [CFG_W-1:0] RUN_RST    = 16'd4000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 8'd0,
		REG_KP     = 8'd1,
		REG_KI     = 8'd2,
		REG_RUN    = 8'd3
	} cfg_reg_t;

	// what the drive register does for one tick
	typedef enum logic [1:0] {
		PWM_HOLD = 2'd0,
		PWM_ZERO = 2'd1,
		PWM_CALC = 2'd2
	} pwm_op_t;

	typedef struct packed {
		pwm_op_t            op;
		logic [CNT_W-1:0]   err;
		logic [INTEG_W-1:0] integ;
		logic [CNT_W-1:0]   count;
		logic               reached;
		logic               running;
	} pi_req_t;

	typedef struct packed {
		pwm_op_t              op;
		logic [PROD_KP_W-1:0] prod_kp;
		logic [PROD_KI_W-1:0] prod_ki;
		logic [CNT_W-1:0]     count;
		logic                 reached;
		logic                 running;
	} pi_prod_t;

endpackage

// ----- sv/mppc_if.sv -----
// Channel interfaces: tick input, result output and configuration writes.
// Depends on mppc_pkg for widths.
interface mppc_tick_if;
	logic valid;
	logic ready;
	logic enc_a;
	logic enc_b;
	logic restart;
	modport source (output valid, enc_a, enc_b, restart, input ready);
	modport sink (input valid, enc_a, enc_b, restart, output ready);
endinterface

interface mppc_result_if;
	logic                         valid;
	logic                         ready;
	logic [mppc_pkg::PWM_W-1:0]   pwm;
	logic [mppc_pkg::CNT_W-1:0]   edge_count;
	logic                         target_reached;
	logic                         running;
	modport source (output valid, pwm, edge_count, target_reached, running, input ready);
	modport sink (input valid, pwm, edge_count, target_reached, running, output ready);
endinterface

interface mppc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mppc_pkg::CFG_IDX_W-1:0] reg_idx;
	logic [mppc_pkg::CFG_W-1:0]     wdata;
	modport source (output valid, reg_idx, wdata, input ready);
	modport sink (input valid, reg_idx, wdata, output ready);
endinterface

// ----- sv/mppc_track.sv -----
// Run window, edge counter, control phase and integral update for one tick.
// Depends on mppc_pkg; feeds a pi_req_t to the PI datapath.
module mppc_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic                          enc_a,
	input  logic                          enc_b,
	input  logic                          restart,
	input  logic [mppc_pkg::CFG_W-1:0]    target,
	input  logic [mppc_pkg::CFG_W-1:0]    run_len,
	output mppc_pkg::pi_req_t             req
);

	logic [mppc_pkg::CNT_W-1:0]   count_q, count_d;
	logic                         level_q, level_d;
	logic [mppc_pkg::INTEG_W-1:0] integ_q, integ_d;
	logic [mppc_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [mppc_pkg::CFG_W-1:0]   win_q, win_d;
	logic                         active_q, active_d;

	logic [mppc_pkg::CNT_W-1:0]   cnt0, err;
	logic [mppc_pkg::INTEG_W:0]   integ_sum;
	logic [mppc_pkg::PHASE_W:0]   phase_inc;
	mppc_pkg::pwm_op_t            op;

	always_comb begin
		count_d  = count_q;
		level_d  = level_q;
		integ_d  = integ_q;
		phase_d  = phase_q;
		win_d    = win_q;
		active_d = active_q;
		op       = mppc_pkg::PWM_HOLD;
		err      = '0;
		integ_sum = '0;
		phase_inc = '0;

		if (restart) begin
			count_d  = '0;
			integ_d  = '0;
			phase_d  = '0;
			win_d    = (run_len == '0) ? mppc_pkg::CFG_W'(1) : run_len;
			active_d = 1'b1;
			op       = mppc_pkg::PWM_ZERO;
		end
		cnt0 = count_d;

		if (active_d) begin
			// PI step sees the count from before this tick's edge
			if (phase_d == '0) begin
				if (cnt0 >= target) begin
					op      = mppc_pkg::PWM_ZERO;
					integ_d = '0;
				end else begin
					op        = mppc_pkg::PWM_CALC;
					err       = target - cnt0;
					integ_sum = {1'b0, integ_d} + (mppc_pkg::INTEG_W+1)'(err);
					integ_d   = integ_sum[mppc_pkg::INTEG_W] ? '1
						: integ_sum[mppc_pkg::INTEG_W-1:0];
				end
			end
			if ((enc_a ^ enc_b) != level_q) begin
				level_d = enc_a ^ enc_b;
				if (cnt0 != '1)
					count_d = cnt0 + 1'b1;
			end
			phase_inc = {1'b0, phase_d} + 1'b1;
			phase_d = (phase_inc >= (mppc_pkg::PHASE_W+1)'(mppc_pkg::CTRL_PERIOD)) ? '0
				: phase_inc[mppc_pkg::PHASE_W-1:0];
			if (win_d != '0)
				win_d = win_d - 1'b1;
			if (win_d == '0) begin
				active_d = 1'b0;
				op       = mppc_pkg::PWM_ZERO;
			end
		end

		req.op      = op;
		req.err     = err;
		req.integ   = integ_d;
		req.count   = count_d;
		req.reached = (count_d >= target);
		req.running = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			level_q  <= 1'b0;
			integ_q  <= '0;
			phase_q  <= '0;
			win_q    <= '0;
			active_q <= 1'b0;
		end else if (fire) begin
			count_q  <= count_d;
			level_q  <= level_d;
			integ_q  <= integ_d;
			phase_q  <= phase_d;
			win_q    <= win_d;
			active_q <= active_d;
		end
	end

endmodule

// ----- sv/mppc_pi.sv -----
// PI datapath: gain products in one stage, sum, shift and clamp into the
// drive register in the next. Depends on mppc_pkg.
module mppc_pi (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load_s2,
	input  logic                          load_s3,
	input  logic                          load_out,
	input  mppc_pkg::pi_req_t             req,
	input  logic [mppc_pkg::CFG_W-1:0]    kp,
	input  logic [mppc_pkg::CFG_W-1:0]    ki,
	output logic [mppc_pkg::PWM_W-1:0]    pwm,
	output logic [mppc_pkg::CNT_W-1:0]    edge_count,
	output logic                          target_reached,
	output logic                          running
);

	mppc_pkg::pi_req_t            req_s2;
	mppc_pkg::pi_prod_t           prod_s3;
	logic [mppc_pkg::SUM_W-1:0]   sum;
	logic [mppc_pkg::PWM_W-1:0]   pwm_calc;
	logic [mppc_pkg::PWM_W-1:0]   pwm_q;
	logic [mppc_pkg::CNT_W-1:0]   count_q;
	logic                         reached_q;
	logic                         running_q;

	always_ff @(posedge clk) begin
		if (load_s2)
			req_s2 <= req;
		if (load_s3) begin
			prod_s3.op      <= req_s2.op;
			prod_s3.prod_kp <= kp * req_s2.err;
			prod_s3.prod_ki <= ki * req_s2.integ;
			prod_s3.count   <= req_s2.count;
			prod_s3.reached <= req_s2.reached;
			prod_s3.running <= req_s2.running;
		end
	end

	// Q8.8 gains: drop the sum's 8 fraction bits, saturate above 255
	always_comb begin
		sum = mppc_pkg::SUM_W'(prod_s3.prod_kp) + mppc_pkg::SUM_W'(prod_s3.prod_ki);
		pwm_calc = (|sum[mppc_pkg::SUM_W-1:2*mppc_pkg::PWM_W]) ? '1
			: sum[2*mppc_pkg::PWM_W-1:mppc_pkg::PWM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_q     <= '0;
			count_q   <= '0;
			reached_q <= 1'b0;
			running_q <= 1'b0;
		end else if (load_out) begin
			case (prod_s3.op)
				mppc_pkg::PWM_HOLD: pwm_q <= pwm_q;
				mppc_pkg::PWM_ZERO: pwm_q <= '0;
				mppc_pkg::PWM_CALC: pwm_q <= pwm_calc;
				default:            pwm_q <= pwm_q;
			endcase
			count_q   <= prod_s3.count;
			reached_q <= prod_s3.reached;
			running_q <= prod_s3.running;
		end
	end

	assign pwm            = pwm_q;
	assign edge_count     = count_q;
	assign target_reached = reached_q;
	assign running        = running_q;

endmodule

// ----- sv/motor_position_pi_controller_unit.sv -----
// Top level of the motor position PI controller: config registers, stage
// valids and handshake. Depends on mppc_pkg, mppc_if, mppc_track, mppc_pi.
//
//   channel  dir  accepted when            carries
//   tick     in   tick.valid & tick.ready  enc_a, enc_b, restart
//   result   out  result.valid & ready     pwm, edge_count, target_reached, running
//   cfg      in   cfg.valid & cfg.ready    reg_idx, wdata (always ready)
//
// One tick accepted per cycle while the input stage can move, one result per
// tick, through input register, state update, gain multipliers, sum and clamp.
// Each stage advances when the one after it is empty or moving, so a
// stalled result blocks input only once all four stages are full.
// Reset clears the run state, drive value and stage valids, and loads the
// register defaults.
module motor_position_pi_controller_unit (
	input  logic           clk,
	input  logic           arst_n,
	mppc_tick_if.sink      tick,
	mppc_result_if.source  result,
	mppc_cfg_if.sink       cfg
);

	logic [mppc_pkg::CFG_W-1:0] target_q, kp_q, ki_q, run_q;
	logic v1_q, v2_q, v3_q, ov_q;
	logic rdy1, rdy2, rdy3, rdy_o;
	logic enc_a_s1, enc_b_s1, restart_s1;
	mppc_pkg::pi_req_t req;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= mppc_pkg::TARGET_RST;
			kp_q     <= mppc_pkg::KP_RST;
			ki_q     <= mppc_pkg::KI_RST;
			run_q    <= mppc_pkg::RUN_RST;
		end else if (cfg.valid) begin
			case (cfg.reg_idx)
				mppc_pkg::REG_TARGET: target_q <= cfg.wdata;
				mppc_pkg::REG_KP:     kp_q     <= cfg.wdata;
				mppc_pkg::REG_KI:     ki_q     <= cfg.wdata;
				mppc_pkg::REG_RUN:    run_q    <= cfg.wdata;
				default: ;
			endcase
		end
	end

	assign rdy_o = !ov_q || result.ready;
	assign rdy3  = !v3_q || rdy_o;
	assign rdy2  = !v2_q || rdy3;
	assign rdy1  = !v1_q || rdy2;
	assign tick.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (rdy1)  v1_q <= tick.valid;
			if (rdy2)  v2_q <= v1_q;
			if (rdy3)  v3_q <= v2_q;
			if (rdy_o) ov_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && rdy1) begin
			enc_a_s1   <= tick.enc_a;
			enc_b_s1   <= tick.enc_b;
			restart_s1 <= tick.restart;
		end
	end

	mppc_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (v1_q && rdy2),
		.enc_a   (enc_a_s1),
		.enc_b   (enc_b_s1),
		.restart (restart_s1),
		.target  (target_q),
		.run_len (run_q),
		.req     (req)
	);

	mppc_pi u_pi (
		.clk            (clk),
		.arst_n         (arst_n),
		.load_s2        (v1_q && rdy2),
		.load_s3        (v2_q && rdy3),
		.load_out       (v3_q && rdy_o),
		.req            (req),
		.kp             (kp_q),
		.ki             (ki_q),
		.pwm            (result.pwm),
		.edge_count     (result.edge_count),
		.target_reached (result.target_reached),
		.running        (result.running)
	);

	assign result.valid = ov_q;

endmodule

// ----- sv/mppc_checker.sv -----
// Port-level checks for the motor position PI controller, bound to the top.
// Depends on mppc_pkg and mppc_if.
module mppc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         tick_valid,
	input logic                         tick_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [mppc_pkg::PWM_W-1:0]   pwm,
	input logic [mppc_pkg::CNT_W-1:0]   edge_count,
	input logic                         running
);

	// ticks accepted but not yet delivered; the pipeline holds at most four
	logic [2:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 3'(tick_valid && tick_ready) - 3'(res_valid && res_ready);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(pwm) && $stable(edge_count))
		else $error("result changed while stalled");

	a_idle_drive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !running |-> pwm == '0)
		else $error("drive nonzero outside run window");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 3'd0)
		else $error("result without an accepted tick");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more ticks in flight than pipeline stages");

endmodule

bind motor_position_pi_controller_unit mppc_checker u_mppc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick.valid),
	.tick_ready (tick.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.pwm        (result.pwm),
	.edge_count (result.edge_count),
	.running    (result.running)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for motor_position_pi_controller_unit: directed table, random encoder
// runs and one long window, each result checked against its pinned table value or a local
// PI/edge-count predictor. Depends on mppc_pkg, mppc_if and the controller RTL.
module tb_top;
	import mppc_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_TICKS = 1400;
	localparam int LONG_RUN_TICKS = 250;

	typedef struct packed {
		logic [PWM_W-1:0] pwm;
		logic [CNT_W-1:0] edge_count;
		logic             reached;
		logic             running;
	} drive_out_t;

	typedef struct packed {
		bit         pinned;
		drive_out_t val;
	} pinned_t;

	typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;

	typedef enum int {MOVE_CLEAN, MOVE_SKIP, MOVE_NOISE} motion_t;

	typedef struct packed {
		row_kind_t        kind;
		bit               enc_a;
		bit               enc_b;
		bit               restart;
		cfg_reg_t         which;
		logic [CFG_W-1:0] wdata;
		bit               pinned;
		drive_out_t       want;
	} plan_row_t;

	localparam drive_out_t NO_PIN = '0;

	// enc_a ^ enc_b is tracked through the table so the pinned rows can be read off by hand
	plan_row_t directed_plan [0:37] = '{
		'{ROW_TICK, 0, 0, 0, REG_TARGET, 16'd0, 1, '{8'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1, 1, 0, REG_TARGET, 16'd0, 1, '{8'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 1, 0, 0, REG_TARGET, 16'd0, 1, '{8'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_TICK, 0, 0, 1, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 1, 0, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 1, 1, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 0, 1, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 0, 0, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 0, 0, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 1, 0, 1, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_CFG,  0, 0, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 1, 0, 1, REG_TARGET, 16'd0, 1, '{8'd0, 16'd0, 1'b1, 1'b1}},
		'{ROW_TICK, 0, 0, 0, REG_TARGET, 16'd0, 1, '{8'd0, 16'd1, 1'b1, 1'b1}},
		'{ROW_CFG,  0, 0, 0, REG_TARGET, 16'hFFFF, 0, NO_PIN},
		'{ROW_CFG,  0, 0, 0, REG_KP, 16'hFFFF, 0, NO_PIN},
		'{ROW_CFG,  0, 0, 0, REG_KI, 16'hFFFF, 0, NO_PIN},
		'{ROW_TICK, 0, 0, 1, REG_TARGET, 16'd0, 1, '{8'd255, 16'd0, 1'b0, 1'b1}},
		'{ROW_TICK, 0, 1, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 1, 1, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_CFG,  0, 0, 0, REG_KP, 16'd0, 0, NO_PIN},
		'{ROW_CFG,  0, 0, 0, REG_KI, 16'd0, 0, NO_PIN},
		'{ROW_CFG,  0, 0, 0, REG_RUN, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 1, 0, 1, REG_TARGET, 16'd0, 1, '{8'd0, 16'd1, 1'b0, 1'b0}},
		'{ROW_TICK, 0, 0, 0, REG_TARGET, 16'd0, 1, '{8'd0, 16'd1, 1'b0, 1'b0}},
		'{ROW_CFG,  0, 0, 0, REG_RUN, 16'd1, 0, NO_PIN},
		'{ROW_TICK, 0, 0, 1, REG_TARGET, 16'd0, 1, '{8'd0, 16'd1, 1'b0, 1'b0}},
		'{ROW_CFG,  0, 0, 0, REG_TARGET, 16'd29, 0, NO_PIN},
		'{ROW_CFG,  0, 0, 0, REG_KP, 16'd485, 0, NO_PIN},
		'{ROW_CFG,  0, 0, 0, REG_KI, 16'd8, 0, NO_PIN},
		'{ROW_CFG,  0, 0, 0, REG_RUN, 16'd8, 0, NO_PIN},
		'{ROW_TICK, 0, 1, 1, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 1, 1, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 1, 0, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 0, 0, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 0, 1, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 1, 1, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 1, 1, 0, REG_TARGET, 16'd0, 0, NO_PIN},
		'{ROW_TICK, 1, 0, 0, REG_TARGET, 16'd0, 0, NO_PIN}
	};

	logic clk;
	logic arst_n;

	mppc_tick_if   tick_ch ();
	mppc_result_if res_ch ();
	mppc_cfg_if    cfg_ch ();

	motor_position_pi_controller_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// predictor state
	bit [CFG_W-1:0]   cur_target = TARGET_RST;
	bit [CFG_W-1:0]   cur_kp     = KP_RST;
	bit [CFG_W-1:0]   cur_ki     = KI_RST;
	bit [CFG_W-1:0]   cur_run    = RUN_RST;
	bit [CNT_W-1:0]   p_count    = '0;
	bit               p_level    = 1'b0;
	bit [INTEG_W-1:0] p_integ    = '0;
	bit [PWM_W-1:0]   p_pwm      = '0;
	bit [PHASE_W-1:0] p_phase    = '0;
	bit [CNT_W-1:0]   p_window   = '0;
	bit               p_active   = 1'b0;

	drive_out_t due_results[$];
	pinned_t    pin_q[$];

	bit       calm = 1'b0;
	bit [1:0] enc_pos = '0;
	int       fail_count = 0;
	int       quiet_cycles = 0;
	int       results_checked = 0;
	int       cfg_writes = 0;
	int       directed_ticks = 0;
	int       random_ticks = 0;
	int       long_run_ticks = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one tick of the controller: restart, PI update on phase 0, edge count, window
	function automatic drive_out_t next_drive(bit a, bit b, bit rs);
		drive_out_t       o;
		bit [CNT_W-1:0]   err;
		bit [INTEG_W:0]   integ_sum;
		bit [65:0]        duty;
		if (rs) begin
			p_count = '0;
			p_integ = '0;
			p_pwm = '0;
			p_phase = '0;
			p_window = (cur_run == 0) ? 16'd1 : cur_run;
			p_active = 1'b1;
		end
		if (p_active) begin
			if (p_phase == 0) begin
				if (p_count >= cur_target) begin
					p_pwm = '0;
					p_integ = '0;
				end else begin
					err = cur_target - p_count;
					integ_sum = {1'b0, p_integ} + err;
					p_integ = integ_sum[INTEG_W] ? '1 : integ_sum[INTEG_W-1:0];
					duty = (66'(cur_kp) * 66'(err) + 66'(cur_ki) * 66'(p_integ)) >> 8;
					p_pwm = (duty > 255) ? 8'hFF : duty[7:0];
				end
			end
			if ((a ^ b) != p_level) begin
				if (p_count != '1)
					p_count = p_count + 1'b1;
				p_level = a ^ b;
			end
			p_phase = (p_phase + 1 >= CTRL_PERIOD) ? '0 : p_phase + 1'b1;
			if (p_window != 0)
				p_window = p_window - 1'b1;
			if (p_window == 0) begin
				p_active = 1'b0;
				p_pwm = '0;
			end
		end
		o.pwm = p_pwm;
		o.edge_count = p_count;
		o.reached = (p_count >= cur_target);
		o.running = p_active;
		return o;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CFG_W-1:0] pick_setting(cfg_reg_t which);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		case (which)
			REG_TARGET: return (r < 4) ? 16'($urandom) : 16'($urandom_range(1, 60));
			REG_KP:     return (r < 4) ? 16'($urandom) : 16'($urandom_range(1, 1500));
			REG_KI:     return (r < 4) ? 16'($urandom) : 16'($urandom_range(1, 120));
			default:    return (r < 3) ? 16'd1 : 16'($urandom_range(2, 150));
		endcase
	endfunction

	task automatic send_tick(input bit a, input bit b, input bit rs, input bit pinned,
			input drive_out_t want);
		int gap;
		gap = pick_gap();
		pin_q.push_back('{pinned, want});
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.enc_a <= a;
		tick_ch.enc_b <= b;
		tick_ch.restart <= rs;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_idx <= idx;
		cfg_ch.wdata <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// hold off new requests until every pending result is back and the pipe is empty
	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// encoder motion, usually opened by a restart; single quadrature steps are one edge each
	task automatic random_run();
		motion_t style;
		int      len;
		int      speed;
		int      r;
		bit      back;
		bit      rs;
		bit      a;
		bit      b;
		r = $urandom_range(0, 9);
		style = (r < 7) ? MOVE_CLEAN : (r < 9) ? MOVE_SKIP : MOVE_NOISE;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 45);
		speed = $urandom_range(10, 100);
		back = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 9) == 0)
			wait_drained();
		for (int k = 0; k <= len; k++) begin
			rs = (k == 0) ? (style != MOVE_NOISE || $urandom_range(0, 1)) :
				($urandom_range(0, 39) == 0);
			if ($urandom_range(0, 19) == 0)
				back = ~back;
			if (style == MOVE_NOISE) begin
				a = $urandom_range(0, 1);
				b = $urandom_range(0, 1);
			end else begin
				if ($urandom_range(0, 99) < speed) begin
					if (style == MOVE_SKIP && $urandom_range(0, 2) == 0)
						enc_pos = enc_pos + 2'd2;
					else
						enc_pos = back ? enc_pos - 1'b1 : enc_pos + 1'b1;
				end
				a = enc_pos[0] ^ enc_pos[1];
				b = enc_pos[1];
			end
			send_tick(a, b, rs, 1'b0, NO_PIN);
			random_ticks++;
		end
	endtask

	task automatic random_phase();
		int phase_end;
		wait_drained();
		calm = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 2) != 0)
			write_cfg(REG_TARGET, pick_setting(REG_TARGET));
		if ($urandom_range(0, 2) != 0)
			write_cfg(REG_KP, pick_setting(REG_KP));
		if ($urandom_range(0, 2) != 0)
			write_cfg(REG_KI, pick_setting(REG_KI));
		if ($urandom_range(0, 2) != 0)
			write_cfg(REG_RUN, pick_setting(REG_RUN));
		// unmapped index, must leave every register alone
		if ($urandom_range(0, 3) == 0)
			write_cfg(CFG_IDX_W'($urandom_range(4, 255)), 16'($urandom));
		phase_end = random_ticks + $urandom_range(80, 220);
		while (random_ticks < phase_end)
			random_run();
	endtask

	initial begin : result_ready
		int hold;
		hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				hold--;
			end else begin
				res_ch.ready <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : monitor
		drive_out_t got;
		drive_out_t want;
		pinned_t    pin;
		bit         moved;
		moved = 1'b0;
		if (cfg_ch.valid && cfg_ch.ready) begin
			moved = 1'b1;
			cfg_writes++;
			case (cfg_ch.reg_idx)
				REG_TARGET: cur_target = cfg_ch.wdata;
				REG_KP:     cur_kp = cfg_ch.wdata;
				REG_KI:     cur_ki = cfg_ch.wdata;
				REG_RUN:    cur_run = cfg_ch.wdata;
				default:    ;
			endcase
		end
		if (tick_ch.valid && tick_ch.ready) begin
			moved = 1'b1;
			want = next_drive(tick_ch.enc_a, tick_ch.enc_b, tick_ch.restart);
			pin = pin_q.pop_front();
			due_results.push_back(pin.pinned ? pin.val : want);
		end
		if (res_ch.valid && res_ch.ready) begin
			moved = 1'b1;
			got = '{res_ch.pwm, res_ch.edge_count, res_ch.target_reached, res_ch.running};
			if (due_results.size() == 0) begin
				$error("result with no tick request pending");
				fail_count++;
			end else begin
				want = due_results.pop_front();
				results_checked++;
				if (got.pwm !== want.pwm) begin
					$error("pwm: expected %0d, got %0d", want.pwm, got.pwm);
					fail_count++;
				end
				if (got.edge_count !== want.edge_count) begin
					$error("edge_count: expected %0d, got %0d", want.edge_count,
						got.edge_count);
					fail_count++;
				end
				if (got.reached !== want.reached) begin
					$error("target_reached: expected %0d, got %0d", want.reached,
						got.reached);
					fail_count++;
				end
				if (got.running !== want.running) begin
					$error("running: expected %0d, got %0d", want.running, got.running);
					fail_count++;
				end
			end
		end
		if (moved) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("motor_position_pi_controller_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		bit after_ticks;
		after_ticks = 1'b0;
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.enc_a = 1'b0;
		tick_ch.enc_b = 1'b0;
		tick_ch.restart = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_idx = '0;
		cfg_ch.wdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_CFG) begin
				if (after_ticks)
					wait_drained();
				after_ticks = 1'b0;
				write_cfg(directed_plan[i].which, directed_plan[i].wdata);
			end else begin
				after_ticks = 1'b1;
				send_tick(directed_plan[i].enc_a, directed_plan[i].enc_b,
					directed_plan[i].restart, directed_plan[i].pinned, directed_plan[i].want);
				directed_ticks++;
			end
		end

		while (random_ticks < RANDOM_TICKS)
			random_phase();

		// long window with an edge on every tick: count climbs steadily, target out of reach
		wait_drained();
		calm = 1'b0;
		write_cfg(REG_RUN, '1);
		write_cfg(REG_TARGET, '1);
		write_cfg(REG_KP, 16'($urandom_range(0, 4000)));
		write_cfg(REG_KI, 16'($urandom_range(0, 300)));
		enc_pos = {1'b0, ~p_level};
		for (int k = 0; k < LONG_RUN_TICKS; k++) begin
			send_tick(enc_pos[0] ^ enc_pos[1], enc_pos[1], k == 0, 1'b0, NO_PIN);
			enc_pos = enc_pos + 1'b1;
			long_run_ticks++;
		end

		wait_drained();
		$display("ticks: %0d directed, %0d random, %0d in one long window; %0d writes",
			directed_ticks, random_ticks, long_run_ticks, cfg_writes);
		$display("results checked: %0d, mismatches: %0d", results_checked, fail_count);
		if (fail_count == 0)
			$display("motor_position_pi_controller_unit regression: pass");
		else
			$display("motor_position_pi_controller_unit regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
sv/mppc_pkg.sv
sv/mppc_if.sv
sv/mppc_track.sv
sv/mppc_pi.sv
sv/motor_position_pi_controller_unit.sv
sv/mppc_checker.sv
tb/sv/tb_top.sv
